FILE: rtl/lbcs_pkg.sv
// Package for the layered box collision scan.
// Holds default sizes, the command codes and the sequencer state type.
// No dependencies.
`default_nettype none

package lbcs_pkg;

	localparam int BOX_COUNT_DEF  = 32;
	localparam int LAYER_BITS_DEF = 3;
	localparam int COORD_BITS_DEF = 16;

	// Fixed widths of the slot fields and of the result mask, and the cap on results per scan.
	localparam int IDX_BITS    = 5;
	localparam int MASK_BITS   = 32;
	localparam int MAX_RESULTS = 32;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_SCAN  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRC,
		ST_SLOAD,
		ST_SWEEP,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/layered_box_collision_scan.sv
// Layered axis-aligned box collision scan: box table in a synchronous memory,
// a scan sequencer and a two-stage pair test. Depends on lbcs_pkg.
//
//   channel  | handshake            | contents
//   ---------+----------------------+------------------------------------------
//   command  | cmd_valid, cmd_stall | command, box_index, box_enabled, layers,
//            |                      | center_x, center_y, width, height
//   result   | res_valid, res_stall | source_index, hit_mask, last
//
// The box memory has a single read port, so a scan reads each enabled source entry and
// then every destination entry in turn. Reset clears the enable bits at once, so there
// is no clearing pass. A stalled result holds the scan at its next result.
`default_nettype none

module layered_box_collision_scan #(
	parameter int BOX_COUNT  = lbcs_pkg::BOX_COUNT_DEF,
	parameter int LAYER_BITS = lbcs_pkg::LAYER_BITS_DEF,
	parameter int COORD_BITS = lbcs_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic                          command,
	input  wire logic [lbcs_pkg::IDX_BITS-1:0] box_index,
	input  wire logic                          box_enabled,
	input  wire logic [LAYER_BITS-1:0]         layer_self,
	input  wire logic [LAYER_BITS-1:0]         layer_target,
	input  wire logic signed [COORD_BITS-1:0]  center_x,
	input  wire logic signed [COORD_BITS-1:0]  center_y,
	input  wire logic [COORD_BITS-1:0]         width,
	input  wire logic [COORD_BITS-1:0]         height,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [lbcs_pkg::IDX_BITS-1:0]      source_index,
	output logic [lbcs_pkg::MASK_BITS-1:0]     hit_mask,
	output logic                               last
);
	import lbcs_pkg::*;

	localparam int IW = $clog2(BOX_COUNT);
	localparam int CW = $clog2(MAX_RESULTS + 1);
	// Doubled interval ends and spans fit in two bits more than a coordinate.
	localparam int EW = COORD_BITS + 2;
	localparam logic [IW-1:0] LAST_IDX = IW'(BOX_COUNT - 1);

	typedef struct packed {
		logic [LAYER_BITS-1:0] lself;
		logic [LAYER_BITS-1:0] ltgt;
		logic [EW-1:0]         xhi;
		logic [EW-1:0]         xlo;
		logic [COORD_BITS-1:0] xsz;
		logic [EW-1:0]         yhi;
		logic [EW-1:0]         ylo;
		logic [COORD_BITS-1:0] ysz;
	} box_t;

	box_t box_mem [BOX_COUNT];
	box_t rd_s1;
	box_t src_box_q;
	box_t wr_box;

	logic [BOX_COUNT-1:0] en_q;
	state_t state_q, state_d;

	logic [IW-1:0] src_q, dst_q, d_s1, d_s2, rd_addr;
	logic [CW-1:0] res_cnt_q;
	logic [MASK_BITS-1:0] mask_q, pend_mask_q, hit_onehot;
	logic [IW-1:0] pend_src_q;
	logic pend_valid_q;
	logic res_valid_q, last_q;
	logic [IDX_BITS-1:0] source_index_q;
	logic [MASK_BITS-1:0] hit_mask_q;

	logic v_s1, v_s2, qual_s2;
	logic [EW-1:0] xspan_s2, xlim_s2, yspan_s2, ylim_s2;

	logic write_en, scan_start, mem_rd, src_inc, out_free;
	logic emit_go, flush_go, out_load, src_last, tgt_none, cnt_full, pair_hit;

	// Doubled center plus and minus the full size gives the doubled interval ends.
	logic [EW-1:0] xc2, yc2, xs, ys;
	always_comb begin
		xc2 = {center_x[COORD_BITS-1], center_x, 1'b0};
		yc2 = {center_y[COORD_BITS-1], center_y, 1'b0};
		xs  = {2'b00, width};
		ys  = {2'b00, height};
		wr_box.lself = layer_self;
		wr_box.ltgt  = layer_target;
		wr_box.xhi   = xc2 + xs;
		wr_box.xlo   = xc2 - xs;
		wr_box.xsz   = width;
		wr_box.yhi   = yc2 + ys;
		wr_box.ylo   = yc2 - ys;
		wr_box.ysz   = height;
	end

	assign src_last = (src_q == LAST_IDX);
	assign tgt_none = (rd_s1.ltgt == '0);
	assign cnt_full = (res_cnt_q == CW'(MAX_RESULTS - 1));
	assign out_free = !res_valid_q || !res_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && command == CMD_SCAN)
					state_d = ST_SRC;
			end
			ST_SRC: begin
				if (en_q[src_q])
					state_d = ST_SLOAD;
				else if (src_last)
					state_d = ST_FLUSH;
			end
			ST_SLOAD: begin
				if (!tgt_none)
					state_d = ST_SWEEP;
				else if (src_last)
					state_d = ST_FLUSH;
				else
					state_d = ST_SRC;
			end
			ST_SWEEP: begin
				if (dst_q == LAST_IDX)
					state_d = ST_DRAIN1;
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!pend_valid_q || out_free)
					state_d = (src_last || cnt_full) ? ST_FLUSH : ST_SRC;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_stall  = 1'b1;
		write_en   = 1'b0;
		scan_start = 1'b0;
		mem_rd     = 1'b0;
		rd_addr    = src_q;
		src_inc    = 1'b0;
		emit_go    = 1'b0;
		flush_go   = 1'b0;
		unique case (state_q) inside
			ST_IDLE: begin
				cmd_stall  = 1'b0;
				write_en   = cmd_valid && command == CMD_WRITE &&
					32'(box_index) < BOX_COUNT;
				scan_start = cmd_valid && command == CMD_SCAN;
			end
			ST_SRC: begin
				mem_rd  = en_q[src_q];
				src_inc = !en_q[src_q];
			end
			ST_SLOAD: src_inc = tgt_none;
			ST_SWEEP: begin
				mem_rd  = 1'b1;
				rd_addr = dst_q;
			end
			ST_DRAIN1, ST_DRAIN2: ;
			ST_EMIT: begin
				emit_go = !pend_valid_q || out_free;
				src_inc = emit_go;
			end
			ST_FLUSH: flush_go = pend_valid_q && out_free;
			default: ;
		endcase
	end

	// A result is held back one source so that the final one can carry last.
	assign out_load = (emit_go && pend_valid_q) || flush_go;

	always_ff @(posedge clk) begin
		if (write_en)
			box_mem[IW'(box_index)] <= wr_box;
		if (mem_rd)
			rd_s1 <= box_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			en_q         <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			res_cnt_q    <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (write_en)
				en_q[IW'(box_index)] <= box_enabled;
			if (scan_start)
				src_q <= '0;
			else if (src_inc)
				src_q <= src_q + 1'b1;
			if (state_q == ST_SLOAD)
				dst_q <= '0;
			else if (state_q == ST_SWEEP)
				dst_q <= dst_q + 1'b1;
			if (scan_start)
				res_cnt_q <= '0;
			else if (emit_go)
				res_cnt_q <= res_cnt_q + 1'b1;
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1;
			if (emit_go)
				pend_valid_q <= 1'b1;
			else if (flush_go)
				pend_valid_q <= 1'b0;
			if (out_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// Pair test, first stage: union span and size limit per axis.
	logic [EW-1:0] xhi_m, xlo_m, yhi_m, ylo_m;
	logic [COORD_BITS:0] xsum, ysum;
	always_comb begin
		xhi_m = ($signed(rd_s1.xhi) > $signed(src_box_q.xhi)) ? rd_s1.xhi : src_box_q.xhi;
		xlo_m = ($signed(rd_s1.xlo) < $signed(src_box_q.xlo)) ? rd_s1.xlo : src_box_q.xlo;
		yhi_m = ($signed(rd_s1.yhi) > $signed(src_box_q.yhi)) ? rd_s1.yhi : src_box_q.yhi;
		ylo_m = ($signed(rd_s1.ylo) < $signed(src_box_q.ylo)) ? rd_s1.ylo : src_box_q.ylo;
		xsum  = {1'b0, rd_s1.xsz} + {1'b0, src_box_q.xsz};
		ysum  = {1'b0, rd_s1.ysz} + {1'b0, src_box_q.ysz};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SLOAD)
			src_box_q <= rd_s1;
		d_s1     <= dst_q;
		d_s2     <= d_s1;
		qual_s2  <= en_q[d_s1] && (d_s1 != src_q) && (rd_s1.lself == src_box_q.ltgt);
		// The span is never negative and stays below two to the EW.
		xspan_s2 <= xhi_m - xlo_m;
		yspan_s2 <= yhi_m - ylo_m;
		xlim_s2  <= {xsum, 1'b0};
		ylim_s2  <= {ysum, 1'b0};
	end

	assign pair_hit = v_s2 && qual_s2 && (xspan_s2 <= xlim_s2) && (yspan_s2 <= ylim_s2);

	always_comb begin
		for (int i = 0; i < MASK_BITS; i++)
			hit_onehot[i] = pair_hit && (i < BOX_COUNT) && (d_s2 == IW'(i));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SLOAD)
			mask_q <= '0;
		else
			mask_q <= mask_q | hit_onehot;
		if (emit_go) begin
			pend_src_q  <= src_q;
			pend_mask_q <= mask_q;
		end
		if (out_load) begin
			source_index_q <= IDX_BITS'(pend_src_q);
			hit_mask_q     <= pend_mask_q;
			last_q         <= flush_go;
		end
	end

	assign res_valid    = res_valid_q;
	assign source_index = source_index_q;
	assign hit_mask     = hit_mask_q;
	assign last         = last_q;

endmodule

`default_nettype wire

FILE: rtl/lbcs_check.sv
// Port-level checks for the layered box collision scan, bound to its top level.
// Depends on lbcs_pkg and layered_box_collision_scan.
`default_nettype none

module lbcs_check (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cmd_valid,
	input wire logic                          cmd_stall,
	input wire logic                          command,
	input wire logic                          res_valid,
	input wire logic                          res_stall,
	input wire logic [lbcs_pkg::IDX_BITS-1:0] source_index,
	input wire logic [lbcs_pkg::MASK_BITS-1:0] hit_mask,
	input wire logic                          last
);
	import lbcs_pkg::*;

	// A stalled result keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(source_index) &&
			$stable(hit_mask) && $stable(last))
		else $error("result changed while stalled");

	// A scan transfer makes the block busy in the next cycle.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && command == CMD_SCAN |=> cmd_stall)
		else $error("command taken right after a scan transfer");

	// A write leaves the command channel free in the next cycle.
	a_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && command == CMD_WRITE |=> !cmd_stall)
		else $error("write held the command channel");

	// New results appear only while a scan is running.
	a_res_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result outside a scan");

endmodule

bind layered_box_collision_scan lbcs_check u_lbcs_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd_valid),
	.cmd_stall    (cmd_stall),
	.command      (command),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.source_index (source_index),
	.hit_mask     (hit_mask),
	.last         (last)
);

`default_nettype wire

FILE: sim/collision_scoreboard_pkg.sv
// Scoreboard for the layered box collision scan testbench.
// Keeps its own copy of the box table and predicts the result stream of every scan.
// Depends on lbcs_pkg.
package collision_scoreboard_pkg;

	import lbcs_pkg::*;

	localparam int SLOTS = BOX_COUNT_DEF;
	localparam int LW    = LAYER_BITS_DEF;
	localparam int CW    = COORD_BITS_DEF;

	typedef struct packed {
		logic [IDX_BITS-1:0]  source_index;
		logic [MASK_BITS-1:0] hit_mask;
		logic                 last;
	} hit_report_t;

	typedef struct {
		bit          enabled;
		logic [LW-1:0] layer_self;
		logic [LW-1:0] layer_target;
		longint      cx;
		longint      cy;
		longint      wd;
		longint      ht;
	} box_entry_t;

	class box_hit_scoreboard;
		box_entry_t  boxes[SLOTS];
		hit_report_t expected_hits[$];
		int          errors;
		int          writes;
		int          scans;
		int          reports;

		function new();
			foreach (boxes[i])
				boxes[i] = '{0, 0, 0, 0, 0, 0, 0};
			errors = 0;
			writes = 0;
			scans = 0;
			reports = 0;
		endfunction

		// Interval ends are taken on doubled coordinates, so 2c +/- s needs no halving.
		static function bit axis_overlap(input longint c1, s1, c2, s2);
			longint hi;
			longint lo;
			hi = (2 * c1 + s1 > 2 * c2 + s2) ? 2 * c1 + s1 : 2 * c2 + s2;
			lo = (2 * c1 - s1 < 2 * c2 - s2) ? 2 * c1 - s1 : 2 * c2 - s2;
			return (hi - lo) <= 2 * (s1 + s2);
		endfunction

		function void predict_scan();
			hit_report_t          rep;
			int                   produced;
			logic [MASK_BITS-1:0] mask;
			produced = 0;
			for (int s = 0; s < SLOTS && produced < MAX_RESULTS; s++) begin
				if (!boxes[s].enabled || boxes[s].layer_target == 0)
					continue;
				mask = '0;
				for (int d = 0; d < SLOTS; d++) begin
					if (d != s && d < MASK_BITS && boxes[d].enabled &&
					    boxes[d].layer_self == boxes[s].layer_target &&
					    axis_overlap(boxes[s].cx, boxes[s].wd, boxes[d].cx, boxes[d].wd) &&
					    axis_overlap(boxes[s].cy, boxes[s].ht, boxes[d].cy, boxes[d].ht))
						mask[d] = 1'b1;
				end
				rep.source_index = IDX_BITS'(s);
				rep.hit_mask = mask;
				rep.last = 1'b0;
				expected_hits = {expected_hits, rep};
				produced++;
			end
			// Only the final result of a scan carries last; an empty scan marks nothing.
			if (produced != 0) begin
				rep = expected_hits[expected_hits.size() - 1];
				rep.last = 1'b1;
				expected_hits[expected_hits.size() - 1] = rep;
			end
		endfunction

		function void note_command(input cmd_t cmd, input logic [IDX_BITS-1:0] idx,
			input logic en, input logic [LW-1:0] ls, lt,
			input logic signed [CW-1:0] x, y, input logic [CW-1:0] w, h);
			if (cmd == CMD_WRITE) begin
				writes++;
				if (idx < SLOTS) begin
					boxes[idx].enabled = en;
					boxes[idx].layer_self = ls;
					boxes[idx].layer_target = lt;
					boxes[idx].cx = x;
					boxes[idx].cy = y;
					boxes[idx].wd = w;
					boxes[idx].ht = h;
				end
			end else begin
				scans++;
				predict_scan();
			end
		endfunction

		function void check_report(input logic [IDX_BITS-1:0] src,
			input logic [MASK_BITS-1:0] mask, input logic lst);
			hit_report_t want;
			reports++;
			if (expected_hits.size() == 0) begin
				$error("result for slot %0d, mask %h, arrived with none expected", src, mask);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (src !== want.source_index) begin
				$error("source_index: expected %0d, actual %0d", want.source_index, src);
				errors++;
			end
			if (mask !== want.hit_mask) begin
				$error("hit_mask: expected %h, actual %h", want.hit_mask, mask);
				errors++;
			end
			if (lst !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, lst);
				errors++;
			end
		endfunction
	endclass

endpackage

FILE: sim/tb_top.sv
// Top of the testbench for the layered box collision scan: clock, reset, command
// driver, result receiver with random stalls and the stimulus sequence.
// Depends on lbcs_pkg, collision_scoreboard_pkg and layered_box_collision_scan.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lbcs_pkg::*;
	import collision_scoreboard_pkg::*;

	localparam int SCAN_CYCLES  = SLOTS * (SLOTS + 5) + 2;
	localparam int RANDOM_ITEMS = 180;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cmd_valid;
	logic                   cmd_stall;
	logic                   command;
	logic [IDX_BITS-1:0]    box_index;
	logic                   box_enabled;
	logic [LW-1:0]          layer_self;
	logic [LW-1:0]          layer_target;
	logic signed [CW-1:0]   center_x;
	logic signed [CW-1:0]   center_y;
	logic [CW-1:0]          width;
	logic [CW-1:0]          height;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	logic [IDX_BITS-1:0]    source_index;
	logic [MASK_BITS-1:0]   hit_mask;
	logic                   last;

	int                     idle_pct;
	int                     stall_pct;
	int                     items_sent;
	box_hit_scoreboard      sb;

	layered_box_collision_scan dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.box_index    (box_index),
		.box_enabled  (box_enabled),
		.layer_self   (layer_self),
		.layer_target (layer_target),
		.center_x     (center_x),
		.center_y     (center_y),
		.width        (width),
		.height       (height),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.source_index (source_index),
		.hit_mask     (hit_mask),
		.last         (last)
	);

	always #5 clk = ~clk;

	// Result side: check each transfer, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_report(source_index, hit_mask, last);
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic drive_item(input cmd_t cmd, input logic [IDX_BITS-1:0] idx,
		input logic en, input logic [LW-1:0] ls, lt,
		input logic signed [CW-1:0] x, y, input logic [CW-1:0] w, h);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		box_index <= idx;
		box_enabled <= en;
		layer_self <= ls;
		layer_target <= lt;
		center_x <= x;
		center_y <= y;
		width <= w;
		height <= h;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_command(cmd, idx, en, ls, lt, x, y, w, h);
		items_sent++;
	endtask

	// The payload fields of a scan are ignored, so they carry noise.
	task automatic scan_table();
		drive_item(CMD_SCAN, IDX_BITS'($urandom), 1'($urandom), LW'($urandom), LW'($urandom),
			CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	// Boxes of one group sit around a shared origin so that pairs overlap often.
	task automatic place_box(input int idx, input longint ox, oy, input bit dense);
		logic [LW-1:0] ls;
		logic [LW-1:0] lt;
		ls = LW'($urandom_range(1, 3));
		lt = dense ? LW'($urandom_range(1, 3)) : LW'($urandom_range(0, 3));
		drive_item(CMD_WRITE, IDX_BITS'(idx), dense || $urandom_range(9) != 0, ls, lt,
			CW'(ox + int'($urandom_range(0, 800)) - 400),
			CW'(oy + int'($urandom_range(0, 800)) - 400),
			CW'($urandom_range(0, 600)), CW'($urandom_range(0, 600)));
	endtask

	initial begin : stimulus
		longint ox;
		longint oy;
		int     base;
		sb = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		command = CMD_WRITE;
		box_index = '0;
		box_enabled = 1'b0;
		layer_self = '0;
		layer_target = '0;
		center_x = '0;
		center_y = '0;
		width = '0;
		height = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every slot as disabled so that no scan ever reads an unwritten entry.
		for (int i = 0; i < SLOTS; i++)
			drive_item(CMD_WRITE, IDX_BITS'(i), 1'b0, LW'($urandom), LW'($urandom),
				CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
		// Nothing is enabled, so this scan must return no result at all.
		scan_table();

		// Edges that just touch count as a hit; one step further apart is a miss.
		drive_item(CMD_WRITE, 0, 1'b1, 1, 2, 0, 0, 32, 32);
		drive_item(CMD_WRITE, 1, 1'b1, 2, 1, 32, 0, 32, 32);
		drive_item(CMD_WRITE, 2, 1'b1, 2, 0, -33, 0, 32, 32);
		drive_item(CMD_WRITE, 3, 1'b0, 2, 1, 0, 0, 32, 32);
		// Two zero-size boxes on the same point hit each other but never themselves.
		drive_item(CMD_WRITE, 4, 1'b1, 3, 3, 100, 100, 0, 0);
		drive_item(CMD_WRITE, 5, 1'b1, 3, 3, 100, 100, 0, 0);
		// Opposite corners of the coordinate range with full sizes meet exactly.
		drive_item(CMD_WRITE, 30, 1'b1, 7, 7, -32768, -32768, 65535, 65535);
		drive_item(CMD_WRITE, 31, 1'b1, 7, 7, 32767, 32767, 65535, 65535);
		drive_item(CMD_WRITE, 29, 1'b1, 7, 0, 32767, -32768, 65535, 65534);
		scan_table();
		drive_item(CMD_WRITE, 0, 1'b0, 1, 2, 0, 0, 32, 32);
		drive_item(CMD_WRITE, 6, 1'b1, 4, 5, -100, 200, 10, 20);
		drive_item(CMD_SCAN, '1, 1'b1, '1, '1, '1, '1, '1, '1);

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			case ((items_sent - base) * 4 / RANDOM_ITEMS)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 53;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 53;
				end
				default: begin
					idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			if ($urandom_range(4) == 0) begin
				if ($urandom_range(1) == 1)
					scan_table();
				else
					drive_item(CMD_WRITE, IDX_BITS'($urandom), 1'($urandom), LW'($urandom),
						LW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
						CW'($urandom));
			end else begin
				ox = longint'($urandom_range(0, 65535)) - 32768;
				oy = longint'($urandom_range(0, 65535)) - 32768;
				// Now and then the whole table becomes active sources, the longest scan.
				if ($urandom_range(5) == 0) begin
					for (int i = 0; i < SLOTS; i++)
						place_box(i, ox, oy, 1'b1);
				end else begin
					repeat ($urandom_range(1, 8))
						place_box($urandom_range(0, SLOTS - 1), ox, oy, 1'b0);
				end
				scan_table();
			end
		end
		cmd_valid <= 1'b0;

		while (sb.expected_hits.size() != 0)
			@(posedge clk);
		repeat (SCAN_CYCLES) @(posedge clk);

		$display("Covered %0d box writes and %0d scans under four idle and stall mixes;",
			sb.writes, sb.scans);
		$display("%0d scan results were compared field by field.", sb.reports);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
